### sv/tmg_pkg.sv
// shared types and constants for the two-run merge
package tmg_pkg;

  localparam int RUN_DEPTH    = 32;
  localparam int ELEMENT_BITS = 32;
  localparam int VALUE_BITS   = 32;
  localparam int CNT_W        = $clog2(RUN_DEPTH + 1);
  localparam int PTR_W        = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;

  typedef struct packed {
    logic                         run_select;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_of_run;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] merged_value;
    logic                         last_merged;
    logic                         overflow;
  } out_item_t;

  // classified element handed from front to back
  typedef struct packed {
    logic  run_b;
    elem_t elem;
    logic  last;
  } cls_item_t;

endpackage

### sv/tmg_front.sv
// front end: accepts input transactions, classifies them, buffers two
module tmg_front
  import tmg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      cls_valid,
  output cls_item_t cls_data,
  input  logic      cls_take
);

  cls_item_t  buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  cls_item_t  cls_in;

  // trim value to element width and tag its run
  always_comb begin
    cls_in.run_b = in_data.run_select;
    cls_in.elem  = in_data.value[ELEMENT_BITS-1:0];
    cls_in.last  = in_data.last_of_run;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cls_valid = (cnt_r != 2'd0);
  assign cls_data  = buf_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cls_take && cls_valid;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= cls_in;
    end
  end

endmodule

### sv/tmg_runq.sv
// one run queue: memory plus registered head element
module tmg_runq
  import tmg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             pop,
  input  elem_t            din,
  output elem_t            head,
  output logic [CNT_W-1:0] count
);

  elem_t            mem [RUN_DEPTH];
  elem_t            head_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             to_head, mem_we, mem_re;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RUN_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head  = head_r;
  assign count = cnt_r;

  // push into head register when empty, else into memory
  always_comb begin
    to_head    = push && (cnt_r == '0);
    mem_we     = push && (cnt_r != '0);
    mem_re     = pop && (cnt_r > CNT_W'(1));
    wr_ptr_nxt = mem_we ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = mem_re ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // memory write and registered read into the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= din;
    end
    if (to_head) begin
      head_r <= din;
    end else if (mem_re) begin
      head_r <= mem[rd_ptr_r];
    end
  end

endmodule

### sv/tmg_merge.sv
// back end: applies items to the run queues, merges heads, buffers results
module tmg_merge
  import tmg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      cls_valid,
  input  cls_item_t cls_data,
  output logic      cls_take,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic             desc_r;
  logic             ended_a_r, ended_a_nxt;
  logic             ended_b_r, ended_b_nxt;
  logic             dropped_r, dropped_nxt;
  elem_t            head_a, head_b;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic             push_a, push_b, pop_a, pop_b;
  logic             has_a, has_b, a_first, can_emit, emit, fin;
  logic             q_ended, q_full;
  out_item_t        res;

  out_item_t        oq_r [2];
  logic             oq_wr_r, oq_rd_r;
  logic [1:0]       oq_cnt_r;
  logic             oq_full, oq_pop;

  tmg_runq u_qa (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_a),
    .pop   (pop_a),
    .din   (cls_data.elem),
    .head  (head_a),
    .count (cnt_a)
  );

  tmg_runq u_qb (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_b),
    .pop   (pop_b),
    .din   (cls_data.elem),
    .head  (head_b),
    .count (cnt_b)
  );

  assign has_a   = (cnt_a != '0);
  assign has_b   = (cnt_b != '0);
  assign oq_full = (oq_cnt_r == 2'd2);

  // ordering of the two heads, ties go to run b
  assign a_first = desc_r ? (head_a > head_b) : (head_a < head_b);

  // pick a source, emit one result, or else apply the next item
  always_comb begin
    pop_a       = 1'b0;
    pop_b       = 1'b0;
    push_a      = 1'b0;
    push_b      = 1'b0;
    cls_take    = 1'b0;
    fin         = 1'b0;
    ended_a_nxt = ended_a_r;
    ended_b_nxt = ended_b_r;
    dropped_nxt = dropped_r;
    can_emit    = (has_a && has_b) || (has_a && ended_b_r) || (has_b && ended_a_r);
    emit        = can_emit && !oq_full;
    q_ended     = cls_data.run_b ? ended_b_r : ended_a_r;
    q_full      = cls_data.run_b ? (cnt_b >= CNT_W'(RUN_DEPTH))
                                 : (cnt_a >= CNT_W'(RUN_DEPTH));
    if (has_a && has_b) begin
      pop_a = a_first;
      pop_b = !a_first;
    end else if (has_a) begin
      pop_a = 1'b1;
    end else begin
      pop_b = 1'b1;
    end
    pop_a = pop_a && emit;
    pop_b = pop_b && emit;
    fin   = emit && ended_a_r && ended_b_r &&
            ((pop_a && cnt_a == CNT_W'(1) && !has_b) ||
             (pop_b && cnt_b == CNT_W'(1) && !has_a));
    res.merged_value = VALUE_BITS'($unsigned(pop_a ? head_a : head_b));
    res.last_merged  = fin;
    res.overflow     = dropped_r;
    if (fin) begin
      ended_a_nxt = 1'b0;
      ended_b_nxt = 1'b0;
      dropped_nxt = 1'b0;
    end
    if (!can_emit && cls_valid) begin
      cls_take = 1'b1;
      if (q_ended || q_full) begin
        dropped_nxt = 1'b1;
      end else begin
        push_a = !cls_data.run_b;
        push_b = cls_data.run_b;
      end
      if (cls_data.last) begin
        if (cls_data.run_b) begin
          ended_b_nxt = 1'b1;
        end else begin
          ended_a_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r    <= 1'b0;
      ended_a_r <= 1'b0;
      ended_b_r <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
      ended_a_r <= ended_a_nxt;
      ended_b_r <= ended_b_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // two-entry result queue
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_data  = oq_r[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (emit) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_r + {1'b0, emit} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

### sv/two_run_merge_core.sv
// top level of the two-run merge
//
//   port group   direction  handshake           payload
//   in_*         input      in_push / in_full   in_data  (in_item_t)
//   out_*        output     out_pop / out_empty out_data (out_item_t)
//   cfg_*        input      cfg_we              cfg_wdata (descending)
//
// the back end applies one input item to its run queue or emits one merged
// result at a time; it takes no new item while a result can be emitted.
// a two-entry input buffer and a two-entry result queue let each side stall.
// rst_n is synchronous; it clears queue fill levels, run-end flags and the
// drop flag, and sets the order to ascending. no clearing pass is needed.
module two_run_merge_core
  import tmg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      cls_valid;
  logic      cls_take;
  cls_item_t cls_data;

  tmg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_data  (cls_data),
    .cls_take  (cls_take)
  );

  tmg_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cls_valid (cls_valid),
    .cls_data  (cls_data),
    .cls_take  (cls_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
